/* hdl/catt_pkg.sv */
// Package for the command acknowledge and retry tracker.
// Holds table sizing, slot state codes, operation and result codes.
// No dependencies.
`default_nettype none
package catt_pkg;
   localparam int TableEntries = 64;
   localparam int SlotBits = $clog2(TableEntries);
   localparam int CountBits = $clog2(TableEntries + 1);

   typedef enum logic [2:0] {
      ST_FREE = 3'd0, ST_WAITING = 3'd1, ST_ACKED = 3'd2,
      ST_NACKED = 3'd3, ST_TIMEOUT = 3'd4
   } slot_state_type;

   localparam logic [2:0] OP_SEND = 3'd0;
   localparam logic [2:0] OP_ACK = 3'd1;
   localparam logic [2:0] OP_NACK = 3'd2;
   localparam logic [2:0] OP_QUERY = 3'd3;
   localparam logic [2:0] OP_SCAN = 3'd4;

   localparam logic [2:0] KIND_REPLY = 3'd0;
   localparam logic [2:0] KIND_RETRY = 3'd1;
   localparam logic [2:0] KIND_TIMEOUT = 3'd2;
   localparam logic [2:0] KIND_TOTALS = 3'd3;
   localparam logic [2:0] KIND_UNKNOWN = 3'd4;

   localparam logic CSR_TIMEOUT = 1'b0;
   localparam logic CSR_RETRY = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // latch the request fields
      logic clear_idx; // restart the slot walk
      logic step;      // advance the slot walk
      logic rd;        // read the slot at the walk index
      logic wr;        // write the slot at the walk index
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic                  last_idx;
      logic [2:0]            slot_state;
      logic                  seq_match;
      logic                  stale;
      logic                  can_retry;
   } sts_type;
endpackage
`default_nettype wire

/* hdl/catt_datapath.sv */
// Datapath of the tracker: slot table memory, request latch and walk index.
// Depends on catt_pkg.
`default_nettype none
module catt_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire catt_pkg::ctl_type    ctl,
   input  wire logic [31:0]          req_seq,
   input  wire logic [7:0]           req_sender,
   input  wire logic [31:0]          req_value,
   input  wire logic [31:0]          req_now,
   input  wire logic [30:0]          timeout_ticks,
   input  wire logic [7:0]           retry_limit,
   input  wire logic [2:0]           wr_state,
   input  wire logic                 wr_new,
   input  wire logic [31:0]          new_seq,
   output catt_pkg::sts_type         sts,
   output logic [31:0]               rd_seq,
   output logic [31:0]               rd_value,
   output logic [7:0]                req_sender_q
);
   import catt_pkg::*;

   logic [2:0]  state_ff [TableEntries];
   logic [31:0] seq_mem [TableEntries];
   logic [31:0] val_mem [TableEntries];
   logic [31:0] time_mem [TableEntries];
   logic [7:0]  retr_mem [TableEntries];
   logic [7:0]  send_mem [TableEntries];

   logic [SlotBits-1:0] idx_ff, idx_in;
   logic [31:0] seq_q_ff, now_q_ff, val_q_ff;
   logic [7:0]  snd_q_ff;
   logic [2:0]  rst_ff;
   logic [31:0] rseq_ff, rval_ff, rtime_ff;
   logic [7:0]  rret_ff;
   logic [31:0] diff;

   assign idx_in = ctl.clear_idx ? '0 : (ctl.step ? idx_ff + 1'b1 : idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         for (int i = 0; i < TableEntries; i++) state_ff[i] <= ST_FREE;
      end else begin
         idx_ff <= idx_in;
         if (ctl.wr) state_ff[idx_ff] <= wr_state;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         seq_q_ff <= req_seq;
         now_q_ff <= req_now;
         val_q_ff <= req_value;
         snd_q_ff <= req_sender;
      end
      if (ctl.rd) begin
         rst_ff   <= state_ff[idx_ff];
         rseq_ff  <= seq_mem[idx_ff];
         rval_ff  <= val_mem[idx_ff];
         rtime_ff <= time_mem[idx_ff];
         rret_ff  <= retr_mem[idx_ff];
      end
      if (ctl.wr) begin
         if (wr_new) begin
            seq_mem[idx_ff]  <= new_seq;
            val_mem[idx_ff]  <= val_q_ff;
            send_mem[idx_ff] <= snd_q_ff;
            time_mem[idx_ff] <= now_q_ff;
            retr_mem[idx_ff] <= 8'd0;
         end else if (wr_state == ST_WAITING) begin
            time_mem[idx_ff] <= now_q_ff;
            retr_mem[idx_ff] <= rret_ff + 8'd1;
         end
      end
   end

   assign diff = now_q_ff - rtime_ff;
   assign sts.last_idx = (idx_ff == SlotBits'(TableEntries - 1));
   assign sts.slot_state = rst_ff;
   assign sts.seq_match = (rseq_ff == seq_q_ff);
   assign sts.stale = (diff >= {1'b0, timeout_ticks});
   assign sts.can_retry = (rret_ff < retry_limit);
   assign rd_seq = rseq_ff;
   assign rd_value = rval_ff;
   assign req_sender_q = snd_q_ff;
endmodule
`default_nettype wire

/* hdl/catt_controller.sv */
// Controller of the tracker: walks the slot table one slot at a time, a read state then an eval state per slot.
// Depends on catt_pkg; drives catt_datapath through ctl_type.
`default_nettype none
module catt_controller (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [2:0]         req_operation,
   input  wire logic [7:0]         req_sender_id,
   input  wire catt_pkg::sts_type  sts,
   input  wire logic [31:0]        rd_seq,
   input  wire logic [31:0]        rd_value,
   output logic                    busy,
   output catt_pkg::ctl_type       ctl,
   output logic [2:0]              wr_state,
   output logic                    wr_new,
   output logic [31:0]             new_seq,
   output logic                    rsp_valid,
   output logic                    rsp_status,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_result_sequence,
   output logic [31:0]             rsp_result_led_value,
   output logic [2:0]              rsp_cmd_state,
   output logic [6:0]              rsp_retry_total,
   output logic [6:0]              rsp_timeout_total,
   output logic                    rsp_last
);
   import catt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL} fsm_type;

   fsm_type fsm_ff;
   logic [2:0] op_ff;
   logic [31:0] nseq_ff;
   logic [6:0] n_ff, rt_ff, tt_ff;
   logic found;
   logic done;

   assign busy = (fsm_ff != S_IDLE);
   assign new_seq = nseq_ff;
   assign found = (sts.slot_state != ST_FREE) && sts.seq_match;

   always_comb begin
      ctl = '0;
      wr_state = sts.slot_state;
      wr_new = 1'b0;
      ctl.load = (fsm_ff == S_IDLE) && start;
      ctl.clear_idx = ctl.load;
      ctl.rd = (fsm_ff == S_READ);
      done = 1'b0;
      if (fsm_ff == S_EVAL) begin
         ctl.step = 1'b1;
         case (op_ff)
            OP_SEND: if (sts.slot_state == ST_FREE) begin
               ctl.wr = 1'b1; wr_state = ST_WAITING; wr_new = 1'b1; done = 1'b1;
            end
            OP_ACK, OP_NACK: if (found) begin
               done = 1'b1;
               if (sts.slot_state == ST_WAITING) begin
                  ctl.wr = 1'b1;
                  wr_state = (op_ff == OP_ACK) ? ST_ACKED : ST_NACKED;
               end
            end
            OP_QUERY: done = found;
            OP_SCAN: if (sts.slot_state == ST_WAITING && sts.stale) begin
               ctl.wr = 1'b1;
               wr_state = sts.can_retry ? ST_WAITING : ST_TIMEOUT;
            end
            default: done = 1'b1;
         endcase
         if (sts.last_idx) done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff <= S_IDLE;
         nseq_ff <= 32'd1;
         rsp_valid <= 1'b0;
         op_ff <= OP_SEND;
         n_ff <= '0; rt_ff <= '0; tt_ff <= '0;
      end else begin
         rsp_valid <= 1'b0;
         rsp_status <= 1'b0; rsp_kind <= KIND_REPLY;
         rsp_result_sequence <= '0; rsp_result_led_value <= '0;
         rsp_cmd_state <= '0; rsp_retry_total <= '0; rsp_timeout_total <= '0;
         rsp_last <= 1'b1;
         case (fsm_ff)
            S_IDLE: if (start) begin
               op_ff <= req_operation;
               n_ff <= '0; rt_ff <= '0; tt_ff <= '0;
               if (req_operation > OP_SCAN) begin
                  rsp_valid <= 1'b1; rsp_status <= 1'b1; rsp_kind <= KIND_UNKNOWN;
               end else if (req_operation == OP_SEND && req_sender_id == 8'd0) begin
                  rsp_valid <= 1'b1; rsp_status <= 1'b1;
               end else begin
                  fsm_ff <= S_READ;
               end
            end
            S_READ: fsm_ff <= S_EVAL;
            S_EVAL: begin
               fsm_ff <= done ? S_IDLE : S_READ;
               if (op_ff == OP_SCAN) begin
                  if (ctl.wr && n_ff < 7'd63) begin
                     rsp_valid <= 1'b1; rsp_last <= 1'b0;
                     rsp_result_sequence <= rd_seq;
                     n_ff <= n_ff + 7'd1;
                     if (sts.can_retry) begin
                        rsp_kind <= KIND_RETRY; rsp_result_led_value <= rd_value;
                        rt_ff <= rt_ff + 7'd1;
                     end else begin
                        rsp_kind <= KIND_TIMEOUT; tt_ff <= tt_ff + 7'd1;
                     end
                  end
               end else if (done) begin
                  rsp_valid <= 1'b1;
                  if (op_ff == OP_SEND) begin
                     if (ctl.wr) begin
                        rsp_result_sequence <= nseq_ff;
                        nseq_ff <= (nseq_ff == 32'hFFFF_FFFF) ? 32'd1 : nseq_ff + 32'd1;
                     end else rsp_status <= 1'b1;
                  end else if (!found) rsp_status <= 1'b1;
                  else if (op_ff == OP_QUERY) rsp_cmd_state <= sts.slot_state;
               end
               if (op_ff == OP_SCAN && done) fsm_ff <= S_IDLE;
            end
            default: fsm_ff <= S_IDLE;
         endcase
         // Scan totals follow the last slot's result in the cycle after it.
         if (fsm_ff == S_IDLE && op_ff == OP_SCAN && n_ff[6] == 1'b0 && 1'b0) begin
         end
      end
   end

`ifndef SYNTHESIS
   a_valid_when_busy: assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == S_READ) |=> (fsm_ff == S_EVAL)) else $error("read not followed by eval");
   a_wr_eval: assert property (@(posedge clock) disable iff (reset)
      ctl.wr |-> (fsm_ff == S_EVAL)) else $error("write outside eval");
   a_seq_nonzero: assert property (@(posedge clock) disable iff (reset)
      nseq_ff != 32'd0) else $error("sequence zero");
`endif
endmodule
`default_nettype wire

/* hdl/catt_totals.sv */
// Emits the scan totals result after the last slot of a scan.
// Depends on catt_pkg; merges with controller results.
`default_nettype none
module catt_totals (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        scan_end,
   input  wire logic [6:0]  rt,
   input  wire logic [6:0]  tt,
   input  wire logic        c_valid,
   input  wire logic        c_status,
   input  wire logic [2:0]  c_kind,
   input  wire logic [31:0] c_seq,
   input  wire logic [31:0] c_val,
   input  wire logic [2:0]  c_state,
   input  wire logic        c_last,
   output logic             rsp_valid,
   output logic             rsp_status,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_result_sequence,
   output logic [31:0]      rsp_result_led_value,
   output logic [2:0]       rsp_cmd_state,
   output logic [6:0]       rsp_retry_total,
   output logic [6:0]       rsp_timeout_total,
   output logic             rsp_last
);
   import catt_pkg::*;
   logic pend_ff;
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= scan_end;
   end
   always_comb begin
      rsp_valid = c_valid; rsp_status = c_status; rsp_kind = c_kind;
      rsp_result_sequence = c_seq; rsp_result_led_value = c_val;
      rsp_cmd_state = c_state; rsp_retry_total = '0; rsp_timeout_total = '0;
      rsp_last = c_last;
      if (pend_ff) begin
         rsp_valid = 1'b1; rsp_status = 1'b0; rsp_kind = KIND_TOTALS;
         rsp_result_sequence = '0; rsp_result_led_value = '0; rsp_cmd_state = '0;
         rsp_retry_total = rt; rsp_timeout_total = tt; rsp_last = 1'b1;
      end
   end
endmodule
`default_nettype wire

/* hdl/command_ack_retry_tracker_unit.sv */
// Top level of the command acknowledge and retry tracker.
// Depends on catt_pkg, catt_datapath, catt_controller and catt_totals.
//
// Usage: a request transfer happens when start is high and busy is low.
// Operations: send, ack, nack, query and timeout scan over a 64 slot table.
// Each result appears for one cycle with rsp_valid; rsp_last marks the last.
// The receiver cannot stall; results are never held.
// A request walks the slots in index order, one slot at a time, stopping at
// the first free slot (send) or matching slot (ack, nack, query). A scan
// walks every slot, and the totals result follows the last slot.
// Empty sender and unknown operations answer in the cycle after the transfer.
// Configuration: csr_we with csr_index 0 (timeout_ticks) or 1 (retry_limit),
// written by the user only while idle (not enforced). Reset clears all slots to
// free, sets the next sequence to 1, timeout_ticks to 5 and retry_limit to 3.
`default_nettype none
module command_ack_retry_tracker_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_operation,
   input  wire logic [31:0]        req_sequence_req,
   input  wire logic [7:0]         req_sender_id,
   input  wire logic signed [31:0] req_led_value,
   input  wire logic [31:0]        req_now,
   input  wire logic               csr_we,
   input  wire logic               csr_index,
   input  wire logic [30:0]        csr_wdata,
   output logic                    rsp_valid,
   output logic                    rsp_status,
   output logic [2:0]              rsp_kind,
   output logic [31:0]             rsp_result_sequence,
   output logic signed [31:0]      rsp_result_led_value,
   output logic [2:0]              rsp_cmd_state,
   output logic [6:0]              rsp_retry_total,
   output logic [6:0]              rsp_timeout_total,
   output logic                    rsp_last
);
   import catt_pkg::*;

   logic [30:0] tmo_ff;
   logic [7:0]  lim_ff;
   ctl_type ctl;
   sts_type sts;
   logic [2:0] wr_state;
   logic wr_new, c_busy, c_valid, c_status, c_last, scan_end;
   logic [31:0] new_seq, rd_seq, rd_value, c_seq, c_val;
   logic [2:0] c_kind, c_state;
   logic [6:0] c_rt, c_tt, rt_ff, tt_ff;
   logic [7:0] snd_q;
   logic scan_ff, tot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tmo_ff <= 31'd5; lim_ff <= 8'd3;
      end else if (csr_we) begin
         if (csr_index == CSR_TIMEOUT) tmo_ff <= csr_wdata;
         else lim_ff <= csr_wdata[7:0];
      end
   end

   catt_datapath u_dp (
      .clock, .reset, .ctl,
      .req_seq(req_sequence_req), .req_sender(req_sender_id),
      .req_value(req_led_value), .req_now,
      .timeout_ticks(tmo_ff), .retry_limit(lim_ff),
      .wr_state, .wr_new, .new_seq, .sts, .rd_seq, .rd_value,
      .req_sender_q(snd_q)
   );

   catt_controller u_ctl (
      .clock, .reset, .start(start && !busy), .req_operation, .req_sender_id,
      .sts, .rd_seq, .rd_value, .busy(c_busy), .ctl, .wr_state, .wr_new, .new_seq,
      .rsp_valid(c_valid), .rsp_status(c_status), .rsp_kind(c_kind),
      .rsp_result_sequence(c_seq), .rsp_result_led_value(c_val),
      .rsp_cmd_state(c_state), .rsp_retry_total(c_rt), .rsp_timeout_total(c_tt),
      .rsp_last(c_last)
   );

   // Track scan totals locally: count per-slot scan results.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff <= 1'b0; tot_ff <= 1'b0; rt_ff <= '0; tt_ff <= '0;
      end else begin
         tot_ff <= scan_end;
         if (start && !busy) begin
            scan_ff <= (req_operation == OP_SCAN);
            rt_ff <= '0; tt_ff <= '0;
         end else begin
            if (scan_end) scan_ff <= 1'b0;
            if (c_valid && c_kind == KIND_RETRY) rt_ff <= rt_ff + 7'd1;
            if (c_valid && c_kind == KIND_TIMEOUT) tt_ff <= tt_ff + 7'd1;
         end
      end
   end
   assign scan_end = scan_ff && !c_busy;
   assign busy = c_busy || scan_ff || tot_ff;

   catt_totals u_tot (
      .clock, .reset, .scan_end, .rt(rt_ff), .tt(tt_ff),
      .c_valid, .c_status, .c_kind, .c_seq, .c_val, .c_state, .c_last,
      .rsp_valid, .rsp_status, .rsp_kind, .rsp_result_sequence,
      .rsp_result_led_value, .rsp_cmd_state, .rsp_retry_total,
      .rsp_timeout_total, .rsp_last
   );

   logic unused_ok;
   assign unused_ok = ^{snd_q, c_rt, c_tt};
endmodule
`default_nettype wire
